FILE: rtl/haversine_track_speed_unit_assert.svh
// Assertion macros used by the top-level RTL; they compile away under SYNTHESIS.
`ifndef HAVERSINE_TRACK_SPEED_UNIT_ASSERT_SVH
`define HAVERSINE_TRACK_SPEED_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HTS_ASSERT_IMPL(label, ante, cons, msg)
`define HTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/hts_pkg.sv
package hts_pkg;

  localparam int DEF_CORDIC_ITERATIONS = 32;
  localparam int DEF_ANGLE_FRAC_BITS   = 20;

  // datapath word: Q30 values with headroom for CORDIC growth
  localparam int DP_W   = 34;
  localparam int PROD_W = 2 * DP_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  localparam logic signed [DP_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic signed [DP_W-1:0] DEG2RAD_Q32     = 34'sd74961321;
  localparam logic signed [DP_W-1:0] EARTH_RADIUS_M  = 34'sd6371000;
  localparam logic signed [DP_W-1:0] KMH_FACTOR      = 34'sd18;
  localparam logic signed [DP_W-1:0] DIST_MAX        = 34'sd33554431;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cor_ctl_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [29:0] atan_q30(input logic [5:0] i);
    logic [29:0] v;
    v = '0;
    case (i)
      6'd0:  v = 30'd843314856;
      6'd1:  v = 30'd497837829;
      6'd2:  v = 30'd263043836;
      6'd3:  v = 30'd133525158;
      6'd4:  v = 30'd67021686;
      6'd5:  v = 30'd33543515;
      6'd6:  v = 30'd16775850;
      6'd7:  v = 30'd8388437;
      6'd8:  v = 30'd4194282;
      6'd9:  v = 30'd2097149;
      6'd10: v = 30'd1048575;
      6'd11: v = 30'd524287;
      6'd12: v = 30'd262143;
      6'd13: v = 30'd131071;
      6'd14: v = 30'd65535;
      6'd15: v = 30'd32767;
      default: begin
        if (i < 6'd30) v = (30'd1 << (6'd30 - i)) - 30'd1;
        else v = '0;
      end
    endcase
    return v;
  endfunction

  // shift right, round to nearest with halves away from zero
  function automatic logic signed [DP_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                      input int unsigned s);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    r   = (mag + (PROD_W'(1) << (s - 1))) >> s;
    if (v[PROD_W-1]) r = ~r + PROD_W'(1);
    return signed'(r[DP_W-1:0]);
  endfunction

endpackage

FILE: rtl/hts_cordic.sv
module hts_cordic #(
  parameter int ITERATIONS = hts_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hts_pkg::cor_ctl_t                 ctl,
  input  logic signed [hts_pkg::DP_W-1:0]   x_in,
  input  logic signed [hts_pkg::DP_W-1:0]   y_in,
  input  logic signed [hts_pkg::DP_W-1:0]   z_in,
  output logic                              done,
  output logic signed [hts_pkg::DP_W-1:0]   x_out,
  output logic signed [hts_pkg::DP_W-1:0]   y_out,
  output logic signed [hts_pkg::DP_W-1:0]   z_out
);
  import hts_pkg::*;

  localparam int IW = $clog2(ITERATIONS);

  logic [IW-1:0]           idx;
  logic                    busy;
  logic                    vec;
  logic                    up;
  logic signed [DP_W-1:0]  xs;
  logic signed [DP_W-1:0]  ys;
  logic signed [DP_W-1:0]  at;

  always_comb begin
    up = vec ? y_out[DP_W-1] : !z_out[DP_W-1];
    xs = x_out >>> idx;
    ys = y_out >>> idx;
    at = signed'(DP_W'(atan_q30(6'(idx))));
  end

  // pulse done the cycle after the last micro-rotation
  always_ff @(posedge clk) begin
    done <= !rst && busy && (idx == IW'(ITERATIONS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (ctl.start && !busy) begin
      busy  <= 1'b1;
      vec   <= ctl.vectoring;
      idx   <= '0;
      x_out <= x_in;
      y_out <= y_in;
      z_out <= z_in;
    end else if (busy) begin
      if (up) begin
        x_out <= x_out - ys;
        y_out <= y_out + xs;
        z_out <= z_out - at;
      end else begin
        x_out <= x_out + ys;
        y_out <= y_out - xs;
        z_out <= z_out + at;
      end
      if (idx == IW'(ITERATIONS - 1)) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/haversine_track_speed_unit.sv
// Work per accepted fix: five CORDIC runs on one shared unit, two 32-step square
// roots, a 38-step divide, a longitude reduction (two steps at defaults) and a few
// multiply steps on one shared 34x34 multiplier. A new fix is accepted only in the
// idle state, so each computed fix, including any m_tready wait for the output
// register, finishes before the next is taken; a first or restart fix is only stored.
// Reset: synchronous, active high; clears the sequencer, the stored-fix flag and the
// result valid.
`include "haversine_track_speed_unit_assert.svh"
module haversine_track_speed_unit #(
  parameter int CORDIC_ITERATIONS = hts_pkg::DEF_CORDIC_ITERATIONS,
  parameter int ANGLE_FRAC_BITS   = hts_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // latitude [27:0], longitude [56:28], time_of_day_s [73:57], zero pad
  input  logic [hts_pkg::IN_DATA_W-1:0]      s_tdata,
  // restart_track [0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // speed_kmh_q8 [31:0], distance_m [56:32], zero pad
  output logic [hts_pkg::OUT_DATA_W-1:0]     m_tdata,
  // time_invalid [0]
  output logic                               m_tuser
);
  import hts_pkg::*;

  // Angle constants follow the fraction bits of the input degrees.
  localparam longint SPAN_L  = 64'sd360 <<< ANGLE_FRAC_BITS;
  localparam longint LATL_L  = 64'sd90 <<< ANGLE_FRAC_BITS;
  localparam int     SPAN_CB = $clog2(SPAN_L);
  localparam int     MOD_K   = (SPAN_CB >= 30) ? 0 : 30 - SPAN_CB;
  localparam logic [63:0]            SPAN64  = 64'(SPAN_L);
  localparam logic [DP_W-1:0]        SPAN_U  = DP_W'(SPAN_L);
  localparam logic [DP_W-1:0]        HALF_U  = DP_W'(SPAN_L / 2);
  localparam logic signed [DP_W-1:0] LAT_LIM = DP_W'(LATL_L);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_MOD, ST_WRAP,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_CORD,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5,
    ST_SQA, ST_SQB, ST_VEC,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_DIV, ST_FIN
  } state_t;

  state_t state;

  // stored fix of the current track
  logic signed [27:0] prev_lat;
  logic signed [28:0] prev_lon;
  logic [16:0]        prev_time;
  logic               have_prev;
  // fix under work
  logic signed [27:0] cur_lat;
  logic signed [28:0] cur_lon;
  logic [16:0]        cur_time;

  logic signed [DP_W-1:0]   lat1, lat2, dlat, dlon;
  logic                     dneg;
  logic [29:0]              mod_r;
  logic signed [17:0]       dt;
  logic [5:0]               cnt;

  logic signed [DP_W-1:0]   th [4];
  logic [1:0]               cor_idx;
  logic signed [DP_W-1:0]   c1, c2, sdl, sdo;
  logic signed [DP_W-1:0]   t1, t2, t3;
  logic [30:0]              a_q30;
  logic [62:0]              sq_n, sq_res;
  logic [30:0]              ra, rb;
  logic [31:0]              ang;
  logic signed [DP_W-1:0]   dq;
  logic [24:0]              dist_m;
  logic [19:0]              dv;
  logic [19:0]              rem;
  logic [37:0]              dnum;
  logic                     inv;

  // shared multiplier
  logic signed [DP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  // shared CORDIC
  cor_ctl_t                 cor_ctl;
  logic                     cor_go;
  logic                     cor_done;
  logic signed [DP_W-1:0]   cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;

  // combinational helpers
  logic signed [DP_W-1:0]   lat_prev_e, lat_cur_e, lat1_c, lat2_c;
  logic signed [29:0]       lon_diff;
  logic [63:0]              mod_sub;
  logic [DP_W-1:0]          wrap_m;
  logic signed [DP_W-1:0]   t4, dist_v;
  logic signed [34:0]       a_sum;
  logic [30:0]              a_clamp;
  logic [62:0]              sq_bit, sq_try, sq_res_next, sq_n_next;
  logic                     sq_ge;
  logic [20:0]              rem2;
  logic                     div_ge;
  logic [19:0]              div5;
  logic [37:0]              num;
  logic signed [DP_W:0]     ang2;
  logic [31:0]              speed;

  always_comb begin
    lat_prev_e = DP_W'(prev_lat);
    lat_cur_e  = DP_W'(cur_lat);
    // clamp latitude to the poles
    lat1_c = (lat_prev_e > LAT_LIM) ? LAT_LIM :
             (lat_prev_e < -LAT_LIM) ? -LAT_LIM : lat_prev_e;
    lat2_c = (lat_cur_e > LAT_LIM) ? LAT_LIM :
             (lat_cur_e < -LAT_LIM) ? -LAT_LIM : lat_cur_e;
    lon_diff = 30'(cur_lon) - 30'(prev_lon);

    mod_sub = SPAN64 << cnt;
    wrap_m  = (dneg && (mod_r != '0)) ? SPAN_U - DP_W'(mod_r) : DP_W'(mod_r);

    t4      = rnd_shr(prod, 30);
    a_sum   = 35'(t1) + 35'(t4);
    a_clamp = a_sum[34] ? '0 :
              (a_sum > 35'sd1073741824) ? 31'd1073741824 : a_sum[30:0];

    sq_bit      = 63'(1) << {cnt, 1'b0};
    sq_try      = sq_res + sq_bit;
    sq_ge       = sq_n >= sq_try;
    sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
    sq_n_next   = sq_ge ? sq_n - sq_try : sq_n;

    ang2   = {cor_z, 1'b0};
    dist_v = rnd_shr(prod, 30);

    div5   = {1'b0, dt[16:0], 2'b00} + 20'(dt[16:0]);
    num    = prod[37:0] + 38'(div5 >> 1);
    rem2   = {rem, dnum[37]};
    div_ge = rem2 >= {1'b0, dv};

    speed = inv ? '0 : ((|dnum[37:32]) ? '1 : dnum[31:0]);
  end

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_M0: begin mul_a = lat1; mul_b = DEG2RAD_Q32; end
      ST_M1: begin mul_a = lat2; mul_b = DEG2RAD_Q32; end
      ST_M2: begin mul_a = dlat; mul_b = DEG2RAD_Q32; end
      ST_M3: begin mul_a = dlon; mul_b = DEG2RAD_Q32; end
      ST_A0: begin mul_a = sdl;  mul_b = sdl; end
      ST_A1: begin mul_a = c1;   mul_b = c2; end
      ST_A2: begin mul_a = sdo;  mul_b = sdo; end
      ST_A4: begin mul_a = t2;   mul_b = t3; end
      ST_D0: begin mul_a = EARTH_RADIUS_M; mul_b = signed'(DP_W'(ang)); end
      ST_D2: begin mul_a = dq;   mul_b = KMH_FACTOR; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // CORDIC hookup: rotation for the four angles, vectoring for atan2
  always_comb begin
    cor_ctl.start     = cor_go;
    cor_ctl.vectoring = (state == ST_VEC);
    if (state == ST_VEC) begin
      cor_x0 = signed'(DP_W'(rb));
      cor_y0 = signed'(DP_W'(ra));
      cor_z0 = '0;
    end else begin
      cor_x0 = CORDIC_INV_GAIN;
      cor_y0 = '0;
      cor_z0 = th[cor_idx];
    end
  end

  hts_cordic #(
    .ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cor_ctl),
    .x_in  (cor_x0),
    .y_in  (cor_y0),
    .z_in  (cor_z0),
    .done  (cor_done),
    .x_out (cor_x),
    .y_out (cor_y),
    .z_out (cor_z)
  );

  assign s_tready = (state == ST_IDLE);

  // launch the shared CORDIC the cycle after each hand-off step
  always_ff @(posedge clk) begin
    if (rst) begin
      cor_go <= 1'b0;
    end else begin
      cor_go <= (state == ST_M4) ||
                (state == ST_CORD && cor_done && cor_idx != 2'd3) ||
                (state == ST_SQB && cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      have_prev <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // drop the result once taken
      if (m_tvalid && m_tready && state != ST_FIN) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser || !have_prev) begin
              // first fix of a track: store it, no result
              prev_lat  <= s_tdata[27:0];
              prev_lon  <= s_tdata[56:28];
              prev_time <= s_tdata[73:57];
              have_prev <= 1'b1;
            end else begin
              cur_lat  <= s_tdata[27:0];
              cur_lon  <= s_tdata[56:28];
              cur_time <= s_tdata[73:57];
              state    <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          lat1  <= lat1_c;
          lat2  <= lat2_c;
          dlat  <= lat2_c - lat1_c;
          dneg  <= lon_diff[29];
          mod_r <= lon_diff[29] ? 30'(-lon_diff) : 30'(lon_diff);
          dt    <= signed'({1'b0, cur_time}) - signed'({1'b0, prev_time});
          cnt   <= 6'(MOD_K);
          state <= ST_MOD;
        end
        ST_MOD: begin
          // reduce the longitude step modulo a full turn, one shift a cycle
          if ({34'd0, mod_r} >= mod_sub) mod_r <= mod_r - mod_sub[29:0];
          if (cnt == '0) state <= ST_WRAP;
          else cnt <= cnt - 1'b1;
        end
        ST_WRAP: begin
          dlon  <= (wrap_m >= HALF_U) ? signed'(wrap_m - SPAN_U) : signed'(wrap_m);
          state <= ST_M0;
        end
        ST_M0: state <= ST_M1;
        ST_M1: begin
          th[0] <= rnd_shr(prod, ANGLE_FRAC_BITS + 2);
          state <= ST_M2;
        end
        ST_M2: begin
          th[1] <= rnd_shr(prod, ANGLE_FRAC_BITS + 2);
          state <= ST_M3;
        end
        ST_M3: begin
          th[2] <= rnd_shr(prod, ANGLE_FRAC_BITS + 3);
          state <= ST_M4;
        end
        ST_M4: begin
          th[3]   <= rnd_shr(prod, ANGLE_FRAC_BITS + 3);
          cor_idx <= '0;
          state   <= ST_CORD;
        end
        ST_CORD: begin
          if (cor_done) begin
            case (cor_idx)
              2'd0:    c1  <= cor_x;
              2'd1:    c2  <= cor_x;
              2'd2:    sdl <= cor_y;
              default: sdo <= cor_y;
            endcase
            if (cor_idx == 2'd3) begin
              state <= ST_A0;
            end else begin
              cor_idx <= cor_idx + 1'b1;
            end
          end
        end
        ST_A0: state <= ST_A1;
        ST_A1: begin
          t1    <= rnd_shr(prod, 30);
          state <= ST_A2;
        end
        ST_A2: begin
          t2    <= rnd_shr(prod, 30);
          state <= ST_A3;
        end
        ST_A3: begin
          t3    <= rnd_shr(prod, 30);
          state <= ST_A4;
        end
        ST_A4: state <= ST_A5;
        ST_A5: begin
          a_q30  <= a_clamp;
          sq_n   <= 63'({a_clamp, 30'd0});
          sq_res <= '0;
          cnt    <= 6'd31;
          state  <= ST_SQA;
        end
        ST_SQA: begin
          if (cnt == '0) begin
            ra     <= sq_res_next[30:0];
            sq_n   <= 63'({31'd1073741824 - a_q30, 30'd0});
            sq_res <= '0;
            cnt    <= 6'd31;
            state  <= ST_SQB;
          end else begin
            sq_n   <= sq_n_next;
            sq_res <= sq_res_next;
            cnt    <= cnt - 1'b1;
          end
        end
        ST_SQB: begin
          sq_n   <= sq_n_next;
          sq_res <= sq_res_next;
          if (cnt == '0) begin
            rb     <= sq_res_next[30:0];
            state  <= ST_VEC;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_VEC: begin
          if (cor_done) begin
            ang   <= ang2[DP_W] ? '0 : ang2[31:0];
            state <= ST_D0;
          end
        end
        ST_D0: state <= ST_D1;
        ST_D1: begin
          dq     <= rnd_shr(prod, 22);
          dist_m <= (dist_v > DIST_MAX) ? '1 : dist_v[24:0];
          state  <= ST_D2;
        end
        ST_D2: state <= ST_D3;
        ST_D3: begin
          if (dt <= 18'sd0) begin
            // time did not advance: flag it, speed held at zero
            inv   <= 1'b1;
            state <= ST_FIN;
          end else begin
            inv   <= 1'b0;
            dv    <= div5;
            dnum  <= num;
            rem   <= '0;
            cnt   <= 6'd37;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem  <= div_ge ? 20'(rem2 - {1'b0, dv}) : rem2[19:0];
          dnum <= {dnum[36:0], div_ge};
          if (cnt == '0) state <= ST_FIN;
          else cnt <= cnt - 1'b1;
        end
        ST_FIN: begin
          // wait for the output register to free up, then advance the track
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {7'd0, dist_m, speed};
            m_tuser   <= inv;
            prev_lat  <= cur_lat;
            prev_lon  <= cur_lon;
            prev_time <= cur_time;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `HTS_ASSERT_NEXT(a_restart_no_work, s_tvalid && s_tready && (s_tuser || !have_prev), state == ST_IDLE, "track start must not launch a computation")
  `HTS_ASSERT_IMPL(a_invalid_zero_speed, m_tvalid && m_tuser, m_tdata[31:0] == 32'd0, "invalid time must give zero speed")
  `HTS_ASSERT_IMPL(a_cordic_done_expected, cor_done, state == ST_CORD || state == ST_VEC, "CORDIC finished outside a waiting step")

endmodule

FILE: sim/haversine_track_speed_unit_tb.sv
`timescale 1ns / 1ps
module haversine_track_speed_unit_tb;
  import hts_pkg::*;

  localparam int ITERS       = DEF_CORDIC_ITERATIONS;
  localparam int FRAC        = DEF_ANGLE_FRAC_BITS;
  localparam int RANDOM_FIXES = 1850;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint LAT_LIM = 64'sd90 <<< FRAC;
  localparam longint SPAN = 64'sd360 <<< FRAC;

  typedef struct packed {
    logic [31:0] speed;
    logic [24:0] dist_m;
    logic        bad_time;
  } leg_t;

  typedef struct {
    logic [27:0] lat;
    logic [28:0] lon;
    logic [16:0] tod;
    logic        restart;
    bit          typed;   // speed and time flag written out below
    logic [31:0] speed;
    logic        bad_time;
  } fix_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;

  // stored fix of the current track, mirrored from the block
  longint trk_lat, trk_lon, trk_tod;
  bit     trk_valid;

  leg_t   leg_q[$];
  int     errors = 0;
  int     send_idle = 27;
  int     recv_idle = 27;
  int     quiet = 0;

  haversine_track_speed_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint arc_step(int i);
    longint tab[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767};
    if (i < 16) return tab[i];
    if (i < 30) return (64'sd1 << (30 - i)) - 1;
    return 0;
  endfunction

  // round to nearest, halves away from zero
  function automatic longint round_shift(longint v, int s);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic void rotate(longint theta, output longint cs, output longint sn);
    longint x, y, z, nx;
    x = 652032874; y = 0; z = theta;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end
      x = nx;
    end
    cs = x; sn = y;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint floor_root(longint unsigned n);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint pole_clamp(longint v);
    if (v > LAT_LIM) return LAT_LIM;
    if (v < -LAT_LIM) return -LAT_LIM;
    return v;
  endfunction

  function automatic longint radians(longint deg, int extra);
    return round_shift(deg * 74961321, FRAC + extra);
  endfunction

  // Advance the track with one fix; returns 1 and the leg when a result is due.
  function automatic bit track_leg(logic [27:0] lat_b, logic [28:0] lon_b,
                                   logic [16:0] tod_b, logic restart, output leg_t leg);
    longint lat, lon, tod, la1, la2, dlon, c1, s1, c2, s2, cdl, sdl, cdo, sdo;
    longint hav, ra, rb, ang, dq, dist_m, dt, spd;
    lat = longint'($signed(lat_b));
    lon = longint'($signed(lon_b));
    tod = longint'(tod_b);
    leg = '0;
    if (restart || !trk_valid) begin
      trk_lat = lat; trk_lon = lon; trk_tod = tod; trk_valid = 1;
      return 0;
    end
    la1 = pole_clamp(trk_lat);
    la2 = pole_clamp(lat);
    dlon = (lon - trk_lon) % SPAN;
    if (dlon < 0) dlon += SPAN;
    if (dlon >= SPAN / 2) dlon -= SPAN;
    rotate(radians(la1, 2), c1, s1);
    rotate(radians(la2, 2), c2, s2);
    rotate(radians(la2 - la1, 3), cdl, sdl);
    rotate(radians(dlon, 3), cdo, sdo);
    hav = qmul(sdl, sdl) + qmul(qmul(c1, c2), qmul(sdo, sdo));
    if (hav < 0) hav = 0;
    if (hav > Q30) hav = Q30;
    ra = floor_root(longint'(hav) << 30);
    rb = floor_root(longint'(Q30 - hav) << 30);
    ang = 2 * vector_angle(ra, rb);
    if (ang < 0) ang = 0;
    dq = round_shift(6371000 * ang, 22);
    dist_m = round_shift(6371000 * ang, 30);
    if (dist_m > 33554431) dist_m = 33554431;
    dt = tod - trk_tod;
    if (dt <= 0) begin
      spd = 0; leg.bad_time = 1'b1;
    end else begin
      spd = (dq * 18 + (5 * dt) / 2) / (5 * dt);
      if (spd > 64'hFFFFFFFF) spd = 64'hFFFFFFFF;
    end
    leg.speed = spd[31:0];
    leg.dist_m = dist_m[24:0];
    trk_lat = lat; trk_lon = lon; trk_tod = tod;
    return 1;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- sender
  // Called in the step of a rising edge; returns in the step of the accepting edge.
  task automatic send_fix(fix_row_t r);
    leg_t leg;
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.tod, r.lon, r.lat};
    s_tuser  <= r.restart;
    do @(posedge clk); while (!s_tready);
    if (track_leg(r.lat, r.lon, r.tod, r.restart, leg)) begin
      // typed rows pin speed and time flag; distance still comes from the predictor
      if (r.typed) begin
        if (leg.speed !== r.speed || leg.bad_time !== r.bad_time)
          report_mismatch("typed row disagrees with predictor");
        leg.speed = r.speed;
        leg.bad_time = r.bad_time;
      end
      leg_q.push_back(leg);
    end
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        if (leg_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          leg_t want;
          want = leg_q.pop_front();
          if (m_tdata[31:0] !== want.speed)
            report_mismatch($sformatf("speed %0d, want %0d", m_tdata[31:0], want.speed));
          if (m_tdata[56:32] !== want.dist_m)
            report_mismatch($sformatf("distance %0d, want %0d", m_tdata[56:32], want.dist_m));
          if (m_tuser !== want.bad_time)
            report_mismatch($sformatf("time flag %0b, want %0b", m_tuser, want.bad_time));
        end
      end
    end
  end

  // watchdog: count cycles with no request moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("haversine_track_speed_unit regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic fix_row_t mk(logic [27:0] lat, logic [28:0] lon, logic [16:0] tod,
                                  logic restart, bit typed = 0, logic [31:0] spd = 0,
                                  logic bad = 0);
    fix_row_t r;
    r.lat = lat; r.lon = lon; r.tod = tod; r.restart = restart;
    r.typed = typed; r.speed = spd; r.bad_time = bad;
    return r;
  endfunction

  function automatic logic [27:0] any_lat(longint near, bit local_step);
    if ($urandom_range(9) == 0) return 28'($urandom);
    if (local_step) return 28'(near + $signed($urandom_range(8000)) - 4000);
    return 28'(longint'($urandom_range(2 * LAT_LIM)) - LAT_LIM);
  endfunction

  function automatic logic [28:0] any_lon(longint near, bit local_step);
    if ($urandom_range(9) == 0) return 29'($urandom);
    if (local_step) return 29'(near + $signed($urandom_range(8000)) - 4000);
    return 29'(longint'($urandom_range(2 * (SPAN / 2))) - SPAN / 2);
  endfunction

  initial begin
    fix_row_t dir[$];
    fix_row_t r;
    longint   lat, lon, tod;
    bit       hop;

    // first fix after reset, then extremes, bad times, antipode, midnight wrap
    dir.push_back(mk(28'd0, 29'd0, 17'd0, 1'b0));
    dir.push_back(mk(28'd0, 29'd0, 17'd10, 1'b0));
    dir.push_back(mk(28'h7FFFFFF, 29'h0FFFFFFF, 17'd10, 1'b0, 1, 32'd0, 1'b1));
    dir.push_back(mk(28'h8000000, 29'h10000000, 17'd5, 1'b0, 1, 32'd0, 1'b1));
    dir.push_back(mk(28'(90 << FRAC), 29'h0FFFFFFF, 17'd86399, 1'b0));
    dir.push_back(mk(28'(-(90 << FRAC)), 29'd0, 17'd0, 1'b1));
    dir.push_back(mk(28'(90 << FRAC), 29'd0, 17'd7200, 1'b0));
    dir.push_back(mk(28'd0, 29'd0, 17'd100, 1'b1));
    dir.push_back(mk(28'd0, 29'(180 << FRAC), 17'd101, 1'b0, 1, 32'hFFFFFFFF, 1'b0));
    dir.push_back(mk(28'd0, 29'(-(180 << FRAC)), 17'd131071, 1'b0));
    dir.push_back(mk(28'd1 << 20, 29'd1 << 20, 17'd86399, 1'b1));
    dir.push_back(mk(28'd2 << 20, 29'd1 << 20, 17'd3, 1'b0, 1, 32'd0, 1'b1));
    dir.push_back(mk(28'd2 << 20, 29'd3 << 20, 17'd3603, 1'b0));
    dir.push_back(mk(28'(-(45 << FRAC)), 29'(170 << FRAC), 17'd4000, 1'b0));
    dir.push_back(mk(28'(-(45 << FRAC)), 29'(-(170 << FRAC)), 17'd4001, 1'b0));
    dir.push_back(mk(28'h5555555, 29'h0AAAAAAA, 17'h15555, 1'b0));
    dir.push_back(mk(28'hAAAAAAA, 29'h15555555, 17'h0AAAA, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir[i]) send_fix(dir[i]);

    // hold off until the track has drained
    s_tvalid <= 1'b0;
    while (leg_q.size() != 0) @(posedge clk);
    @(posedge clk);

    lat = 0; lon = 0; tod = 0;
    for (int n = 0; n < RANDOM_FIXES; n++) begin
      // one long stretch with both sides always ready
      send_idle = (n >= 600 && n < 900) ? 0 : 27;
      recv_idle = send_idle;
      hop = ($urandom_range(4) == 0);
      r = mk(any_lat(lat, !hop), any_lon(lon, !hop), 17'd0, ($urandom_range(19) == 0));
      case ($urandom_range(9))
        0:       r.tod = 17'($urandom);
        1:       r.tod = 17'(tod - $urandom_range(3));
        default: r.tod = 17'(tod + $urandom_range(1, 600));
      endcase
      lat = longint'($signed(r.lat));
      lon = longint'($signed(r.lon));
      tod = r.tod;
      send_fix(r);
    end
    s_tvalid <= 1'b0;

    while (leg_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("haversine_track_speed_unit regression: pass");
    end else begin
      $display("haversine_track_speed_unit regression: fail");
    end
    $finish;
  end

endmodule
